// ===== rtl/raycast_wall_column_texturer_macros.svh =====
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_MACROS_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_MACROS_SVH

// Same-cycle implication on clk_i, held off during reset.
`define RCWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, held off during reset.
`define RCWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcwt_pkg.sv =====
package rcwt_pkg;

  localparam int DIVIDEND_W = 27;
  localparam int DIVISOR_W  = 24;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [1:0] REGION_CEILING = 2'd0;
  localparam logic [1:0] REGION_WALL    = 2'd1;
  localparam logic [1:0] REGION_FLOOR   = 2'd2;

  localparam logic [0:0] REG_CEILING = 1'b0;
  localparam logic [0:0] REG_FLOOR   = 1'b1;

  localparam logic [23:0] CEILING_RESET = 24'h0087FF;
  localparam logic [23:0] FLOOR_RESET   = 24'h0F8C12;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [23:0] distance;
    logic        side;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
  } hit_t;

  typedef struct packed {
    logic        load;
    logic [9:0]  first_row;
    logic [9:0]  last_row;
    logic [5:0]  tex_col;
    logic [1:0]  tex_pick;
    logic [31:0] step;
    logic [31:0] position;
  } col_t;

endpackage

// ===== rtl/raycast_wall_column_texturer.sv =====
// Textured wall column generator for a raycaster. A setup request (tuser 0) carries one ray
// hit: the slice height and the texture step are each worked out by one shared 27-step
// restoring divider, one quotient bit per cycle, and the wall hit position and start texture
// row go through one registered multiplier; s_axis_tready is low while the setup runs. Each
// pixel request (tuser 1) gives one pixel for the next screen row, one per cycle while the
// result side keeps taking them; a finished pixel waits in an output register and the next
// request is taken as it leaves.
`include "raycast_wall_column_texturer_macros.svh"

module raycast_wall_column_texturer
  import rcwt_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 600,
  parameter int TEXTURE_SIZE  = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // hit_distance, hit_side, dir_x, dir_y, pos_x, pos_y
  input  logic [111:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row, fill_color, texture_pick, texel_col, texel_row
  output logic [47:0]  m_axis_tdata,
  // region
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [9:0] LAST_ROW     = 10'(SCREEN_HEIGHT - 1);
  localparam logic [5:0] TEX_ROW_MASK = 6'(TEXTURE_SIZE - 1);

  logic [23:0] ceil_q, floor_q;
  logic [9:0]  first_q, last_q, row_q;
  logic [5:0]  tcol_q;
  logic [1:0]  pick_q;
  logic [31:0] step_q, pos_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_last_q;

  hit_t        hit;
  col_t        col;
  logic        setup_busy;
  logic        setup_acc, pixel_acc;
  logic [1:0]  region;
  logic        cfg_wr;

  assign hit.distance = s_axis_tdata[23:0];
  assign hit.side     = s_axis_tdata[24];
  assign hit.dir_x    = s_axis_tdata[42:25];
  assign hit.dir_y    = s_axis_tdata[60:43];
  assign hit.pos_x    = s_axis_tdata[84:61];
  assign hit.pos_y    = s_axis_tdata[108:85];

  assign s_axis_tready = !setup_busy && (!out_valid_q || m_axis_tready);
  assign setup_acc     = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
  assign pixel_acc     = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  rcwt_setup #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXTURE_SIZE  (TEXTURE_SIZE)
  ) u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (setup_acc),
    .hit_i   (hit),
    .busy_o  (setup_busy),
    .col_o   (col)
  );

  always_comb begin
    if (row_q < first_q) begin
      region = REGION_CEILING;
    end else if (row_q <= last_q) begin
      region = REGION_WALL;
    end else begin
      region = REGION_FLOOR;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q  <= CEILING_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_wr) begin
      case (paddr[2:2])
        REG_CEILING: ceil_q  <= pwdata[23:0];
        REG_FLOOR:   floor_q <= pwdata[23:0];
        default:     ceil_q  <= ceil_q;
      endcase
    end
  end

  assign prdata = {8'b0, (paddr[2:2] == REG_FLOOR) ? floor_q : ceil_q};
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
      tcol_q  <= '0;
      pick_q  <= '0;
      step_q  <= '0;
      pos_q   <= '0;
      row_q   <= '0;
    end else if (col.load) begin
      first_q <= col.first_row;
      last_q  <= col.last_row;
      tcol_q  <= col.tex_col;
      pick_q  <= col.tex_pick;
      step_q  <= col.step;
      pos_q   <= col.position;
      row_q   <= '0;
    end else if (pixel_acc) begin
      if (region == REGION_WALL) begin
        pos_q <= pos_q + step_q;
      end
      row_q <= (row_q >= LAST_ROW) ? 10'd0 : row_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pixel_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_acc) begin
      out_user_q <= region;
      out_last_q <= row_q == LAST_ROW;
      if (region == REGION_WALL) begin
        out_data_q <= {pos_q[21:16] & TEX_ROW_MASK, tcol_q, pick_q, 24'd0, row_q};
      end else begin
        out_data_q <= {6'd0, 6'd0, 2'd0,
                       (region == REGION_CEILING) ? ceil_q : floor_q, row_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  `RCWT_ASSERT_IMP(a_no_req_in_setup, setup_busy, !s_axis_tready, "request taken during setup")
  `RCWT_ASSERT_NEXT(a_pixel_result, pixel_acc, m_axis_tvalid, "pixel request gave no result")
  `RCWT_ASSERT_IMP(a_row_in_range, 1'b1, row_q <= LAST_ROW, "row counter past last row")

endmodule

// ===== rtl/rcwt_div.sv =====
module rcwt_div
  import rcwt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVIDEND_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/rcwt_setup.sv =====
module rcwt_setup
  import rcwt_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 600,
  parameter int TEXTURE_SIZE  = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  hit_t hit_i,
  output logic busy_o,
  output col_t col_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_HIT = 3'd1;
  localparam logic [2:0] ST_FRAC    = 3'd2;
  localparam logic [2:0] ST_DIV_H   = 3'd3;
  localparam logic [2:0] ST_DIV_S   = 3'd4;
  localparam logic [2:0] ST_MUL_POS = 3'd5;
  localparam logic [2:0] ST_LOAD    = 3'd6;

  localparam logic [DIVIDEND_W-1:0] SCREEN_NUM = DIVIDEND_W'(SCREEN_HEIGHT) << 16;
  localparam logic [DIVIDEND_W-1:0] TEX_NUM    = DIVIDEND_W'(TEXTURE_SIZE) << 16;
  localparam logic [9:0]            HALF       = 10'(SCREEN_HEIGHT / 2);
  localparam logic [9:0]            LAST_ROW   = 10'(SCREEN_HEIGHT - 1);

  logic [2:0]  state_q, state_d;
  hit_t        hit_q;
  logic signed [43:0] prod_q;
  logic [5:0]  tcol_q;
  logic [1:0]  pick_q;
  logic [9:0]  first_q, last_q;
  logic [15:0] offset_q;
  logic [24:0] step_q;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  hit_t        hit_in;
  logic [25:0] mul_a;
  logic [17:0] mul_b;
  logic [15:0] frac;
  logic [24:0] col_prod;
  logic [15:0] lh;
  logic [14:0] h2;
  logic        over;
  logic [16:0] end_sum;

  rcwt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    hit_in = hit_i;
    if (hit_i.distance == '0) begin
      hit_in.distance = 24'd1;
    end
  end

  assign mul_a = (state_q == ST_MUL_POS) ? {1'b0, step_q} : {2'b00, hit_q.distance};
  assign mul_b = (state_q == ST_MUL_POS) ? {2'b00, offset_q}
               : (hit_q.side ? hit_q.dir_x : hit_q.dir_y);

  assign frac     = (hit_q.side ? hit_q.pos_x[15:0] : hit_q.pos_y[15:0]) + prod_q[31:16];
  assign col_prod = {9'b0, frac} * 25'(TEXTURE_SIZE);

  assign lh      = (|div_rsp.quotient[DIVIDEND_W-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
  assign h2      = lh[15:1];
  assign over    = {2'b00, h2} > {7'b0, HALF};
  assign end_sum = {2'b00, h2} + {7'b0, HALF};

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_FRAC: begin
        div_req.start    = 1'b1;
        div_req.dividend = SCREEN_NUM;
        div_req.divisor  = hit_q.distance;
      end
      ST_DIV_H: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = TEX_NUM;
        div_req.divisor  = (lh == '0) ? DIVISOR_W'(1) : DIVISOR_W'(lh);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (start_i) state_d = ST_MUL_HIT;
      ST_MUL_HIT: state_d = ST_FRAC;
      ST_FRAC:    state_d = ST_DIV_H;
      ST_DIV_H:   if (div_rsp.done) state_d = ST_DIV_S;
      ST_DIV_S:   if (div_rsp.done) state_d = ST_MUL_POS;
      ST_MUL_POS: state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      hit_q <= hit_in;
    end
    if (state_q == ST_MUL_HIT || state_q == ST_MUL_POS) begin
      prod_q <= $signed(mul_a) * $signed(mul_b);
    end
    if (state_q == ST_FRAC) begin
      tcol_q <= col_prod[21:16];
      if (hit_q.side) begin
        pick_q <= hit_q.dir_y[17] ? 2'd0 : 2'd1;
      end else begin
        pick_q <= hit_q.dir_x[17] ? 2'd2 : 2'd3;
      end
    end
    if (state_q == ST_DIV_H && div_rsp.done) begin
      first_q  <= over ? 10'd0 : HALF - h2[9:0];
      offset_q <= over ? 16'({2'b00, h2} - {7'b0, HALF}) : 16'd0;
      last_q   <= (end_sum > {7'b0, LAST_ROW}) ? LAST_ROW : end_sum[9:0];
    end
    if (state_q == ST_DIV_S && div_rsp.done) begin
      step_q <= div_rsp.quotient[24:0];
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign col_o.load     = state_q == ST_LOAD;
  assign col_o.first_row = first_q;
  assign col_o.last_row = last_q;
  assign col_o.tex_col  = tcol_q;
  assign col_o.tex_pick = pick_q;
  assign col_o.step     = {7'b0, step_q};
  assign col_o.position = prod_q[31:0];

endmodule
